// ----- hw/rtl/dspm_pkg.sv -----
// shared constants and types for the dot-star pattern matcher
package dspm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam int CMD_W = 2;
    localparam int SYM_W = 8;

    localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END     = 2'd2;

    localparam logic [SYM_W-1:0] SYM_ANY  = 8'h2E;
    localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;

    typedef struct packed {
        logic             valid;
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] symbol;
    } step_t;

    typedef struct packed {
        logic matched;
        logic pattern_error;
    } verdict_t;

endpackage

// ----- hw/rtl/dspm_core.sv -----
// pattern store and live-position vector, both held in registers
module dspm_core #(
    parameter int MAX_PATTERN = dspm_pkg::MAX_PATTERN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dspm_pkg::step_t   step,
    output dspm_pkg::verdict_t verdict
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PW = MAX_PATTERN + 1;

    logic [dspm_pkg::SYM_W-1:0] bytes_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     star_reg,  star_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [PW-1:0]              live_reg,  live_next;
    logic                       text_reg,  text_next;
    logic                       err_reg,   err_next;

    logic [PW-1:0]          star_ext;
    logic [PW-1:0]          seed;
    logic [PW-1:0]          sum;
    logic [PW-1:0]          carries;
    logic [PW-1:0]          closed;
    logic [MAX_PATTERN-1:0] adv;
    logic [PW-1:0]          step_live;
    logic [IW-1:0]          last_idx;
    logic [IW-1:0]          wr_idx;
    logic                   wr_byte;

    // zero-repeat closure: carries run through each block of starred elements
    // top bit of both operands is zero, so the sum never overflows
    assign star_ext = {1'b0, star_reg};
    assign seed     = live_reg & star_ext;
    assign sum      = seed + star_ext;
    assign carries  = sum ^ seed ^ star_ext;
    assign closed   = live_reg | carries;

    // per-element match against the incoming text byte
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_elem
        localparam logic [CW-1:0] POS = CW'(k);
        assign adv[k] = closed[k] && (POS < count_reg) &&
                        ((bytes_reg[k] == dspm_pkg::SYM_ANY) ||
                         (bytes_reg[k] == step.symbol));
    end

    assign step_live = {1'b0, adv & star_reg} | {adv & ~star_reg, 1'b0};

    assign last_idx = IW'(count_reg - CW'(1));
    assign wr_idx   = IW'(count_reg);

    assign verdict.matched       = !err_reg && closed[count_reg];
    assign verdict.pattern_error = err_reg;

    always_comb
    begin
        star_next  = star_reg;
        count_next = count_reg;
        live_next  = live_reg;
        text_next  = text_reg;
        err_next   = err_reg;
        wr_byte    = 1'b0;
        if (step.valid) begin
            case (step.cmd)
                dspm_pkg::CMD_PATTERN:
                begin
                    if (!text_reg && !err_reg) begin
                        if (step.symbol == dspm_pkg::SYM_STAR) begin
                            if (count_reg == '0 || star_reg[last_idx]) begin
                                err_next = 1'b1;
                            end else begin
                                star_next[last_idx] = 1'b1;
                            end
                        end else if (count_reg >= CW'(MAX_PATTERN)) begin
                            err_next = 1'b1;
                        end else begin
                            wr_byte           = 1'b1;
                            star_next[wr_idx] = 1'b0;
                            count_next        = count_reg + CW'(1);
                        end
                    end
                end
                dspm_pkg::CMD_TEXT:
                begin
                    text_next = 1'b1;
                    live_next = step_live;
                end
                dspm_pkg::CMD_END:
                begin
                    star_next  = '0;
                    count_next = '0;
                    live_next  = PW'(1);
                    text_next  = 1'b0;
                    err_next   = 1'b0;
                end
                default:
                begin
                    wr_byte = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            star_reg  <= '0;
            count_reg <= '0;
            live_reg  <= PW'(1);
            text_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            star_reg  <= star_next;
            count_reg <= count_next;
            live_reg  <= live_next;
            text_reg  <= text_next;
            err_reg   <= err_next;
        end
    end

    // element bytes, only entries below the count are ever looked at
    always_ff @(posedge clk)
    begin
        if (wr_byte) begin
            bytes_reg[wr_idx] <= step.symbol;
        end
    end

endmodule

// ----- hw/rtl/dot_star_pattern_matcher.sv -----
// top level of the dot-star pattern matcher: handshake, input and result registers
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | cmd[1:0], symbol[7:0]
//  out     | output    | out_valid / out_stall| matched, pattern_error
//
// one beat per cycle while in_stall is low; each beat is held in the input
// register and from there is folded into the live-position vector
// an end beat's verdict passes the input and result registers before the outputs
// rst_n clears the pattern, the live vector (position zero only) and both valids
// in_stall rises only when an end beat waits in the input register while a
// previous verdict is still held by out_stall
module dot_star_pattern_matcher #(
    parameter int MAX_PATTERN = dspm_pkg::MAX_PATTERN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [dspm_pkg::CMD_W-1:0] cmd,
    input  logic [dspm_pkg::SYM_W-1:0] symbol,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       matched,
    output logic                       pattern_error
);

    // input register
    logic                       stage_valid_reg, stage_valid_next;
    logic [dspm_pkg::CMD_W-1:0] stage_cmd_reg;
    logic [dspm_pkg::SYM_W-1:0] stage_sym_reg;

    // result register
    logic out_valid_reg, out_valid_next;
    logic matched_reg;
    logic error_reg;

    logic               hold;
    logic               fire;
    logic               fire_end;
    dspm_pkg::step_t    step;
    dspm_pkg::verdict_t verdict;

    // an end beat cannot leave the input register while the last verdict is held
    assign hold = stage_valid_reg && (stage_cmd_reg == dspm_pkg::CMD_END) &&
                  out_valid_reg && out_stall;
    assign fire     = stage_valid_reg && !hold;
    assign fire_end = fire && (stage_cmd_reg == dspm_pkg::CMD_END);

    assign in_stall         = hold;
    assign stage_valid_next = hold ? stage_valid_reg : in_valid;
    assign out_valid_next   = fire_end || (out_valid_reg && out_stall);

    assign step.valid  = fire;
    assign step.cmd    = stage_cmd_reg;
    assign step.symbol = stage_sym_reg;

    dspm_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .verdict (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (!hold) begin
            stage_cmd_reg <= cmd;
            stage_sym_reg <= symbol;
        end
        if (fire_end) begin
            matched_reg <= verdict.matched;
            error_reg   <= verdict.pattern_error;
        end
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign pattern_error = error_reg;

    // a new verdict appears only after an end beat left the input register
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fire_end))
        else $error("verdict without an end beat");

    // the input side is stalled only behind a held verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled with no held verdict");

    // a malformed pattern never reports a match
    a_error_no_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(matched_reg && error_reg))
        else $error("match reported with pattern error");

endmodule
